[hdl/mhpq_pkg.sv]
// Package for the max-heap priority queue unit.
// Holds sizes, op and status codes, and the sequencer state type. No dependencies.
`default_nettype none
package mhpq_pkg;
    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int VISIT_BITS = 32;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD_ROOT,
        S_EX_RD_LAST,
        S_DN_RD_L,
        S_DN_RD_R,
        S_DN_CMP,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

[hdl/max_heap_priority_queue_unit.sv]
// Max-heap priority queue: top level with heap memory and sift sequencer.
// Depends on mhpq_pkg.
//
// Steps per item: an enqueue reads and compares the parent per sift-up swap, stopping at a
// parent that is not smaller or writing at the root; an extract reads the root and the last
// element, then per sift-down visit reads both children and compares (visits = swaps + 1,
// or none if the heap empties); refused ops go to output. The single-read-port heap memory paces each level.
// Throughput: one item at a time; the next item is taken the cycle after the result.
// Reset: asynchronous, clears fill count, visit counter and sequencer; heap memory
// is not cleared (entries are read only after being written).
`default_nettype none
module max_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] value, [39:32] zero
    input  wire logic        s_axis_tuser,  // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata   // [31:0] removed_value, [42:32] element_count,
                                            // [74:43] heapify_total, [76:75] status, [79:77] 0
);
    // heap memory, index = node - 1 (nodes are one-based)
    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    state_t state_reg, state_next;
    logic [COUNT_BITS-1:0] fill_reg, fill_next;
    logic [VISIT_BITS-1:0] visit_reg, visit_next;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;       // current node (one-based)
    logic [VALUE_BITS-1:0] cur_reg, cur_next;       // value being moved
    logic [VALUE_BITS-1:0] lval_reg, lval_next;     // left child value
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [1:0]            status_reg, status_next;

    // marks the first sift-down pass, where rdata carries the old last element
    logic first_dn_reg;

    // children of pos, one bit wider so they can exceed the fill count
    logic [COUNT_BITS:0] lc, rc;
    assign lc = {pos_reg, 1'b0};
    assign rc = {pos_reg, 1'b1};
    logic [COUNT_BITS-1:0] parent;
    assign parent = pos_reg >> 1;

    logic l_in, r_in;
    assign l_in = lc <= {1'b0, fill_reg};
    assign r_in = rc <= {1'b0, fill_reg};

    function automatic logic [ADDR_BITS-1:0] addr_of(input logic [COUNT_BITS:0] node);
        logic [COUNT_BITS:0] a;
        a = node - 1'b1;
        return a[ADDR_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            visit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            visit_reg <= visit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        lval_reg   <= lval_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        logic signed [VALUE_BITS-1:0] big_v;
        logic [COUNT_BITS:0]          big_n;
        logic [VISIT_BITS-1:0]        vinc;
        state_next  = state_reg;
        fill_next   = fill_reg;
        visit_next  = visit_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        lval_next   = lval_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = cur_reg;
        raddr       = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        vinc = (visit_reg == '1) ? visit_reg : visit_reg + 1'b1;
        big_v = '0;
        big_n = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    rem_next    = '0;
                    status_next = ST_OK;
                    if (s_axis_tuser == OP_ENQUEUE)
                    begin
                        if (fill_reg == COUNT_BITS'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            fill_next  = fill_reg + 1'b1;
                            pos_next   = fill_reg + 1'b1;
                            cur_next   = s_axis_tdata[VALUE_BITS-1:0];
                            state_next = S_UP_RD;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_EX_RD_ROOT;
                    end
                end
            end
            S_UP_RD:
            begin
                // read parent; at root write and finish
                if (pos_reg == COUNT_BITS'(1))
                begin
                    we         = 1'b1;
                    waddr      = addr_of({1'b0, pos_reg});
                    state_next = S_OUT;
                end
                else
                begin
                    raddr      = addr_of({1'b0, parent});
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if ($signed(rdata) < $signed(cur_reg))
                begin
                    waddr      = addr_of({1'b0, pos_reg});
                    wdata      = rdata;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    waddr      = addr_of({1'b0, pos_reg});
                    state_next = S_OUT;
                end
            end
            S_EX_RD_ROOT:
            begin
                raddr      = '0;
                state_next = S_EX_RD_LAST;
            end
            S_EX_RD_LAST:
            begin
                rem_next   = rdata;
                raddr      = addr_of({1'b0, fill_reg});
                fill_next  = fill_reg - 1'b1;
                pos_next   = COUNT_BITS'(1);
                state_next = S_DN_RD_L;
            end
            S_DN_RD_L:
            begin
                // first pass: rdata holds the old last element
                raddr      = addr_of(lc);
                state_next = S_DN_RD_R;
            end
            S_DN_RD_R:
            begin
                lval_next  = rdata;
                raddr      = addr_of(rc);
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (fill_reg != '0)
                begin
                    visit_next = vinc;
                end
                big_v = cur_reg;
                big_n = {1'b0, pos_reg};
                if (l_in && big_v < $signed(lval_reg))
                begin
                    big_v = lval_reg;
                    big_n = lc;
                end
                if (r_in && big_v < $signed(rdata))
                begin
                    big_v = rdata;
                    big_n = rc;
                end
                we    = 1'b1;
                waddr = addr_of({1'b0, pos_reg});
                if (big_n == {1'b0, pos_reg})
                begin
                    wdata      = cur_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    wdata      = big_v;
                    pos_next   = big_n[COUNT_BITS-1:0];
                    state_next = S_DN_RD_L;
                end
            end
            S_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // moved element: last element value captured on entering sift-down
        if (state_reg == S_DN_RD_L && pos_reg == COUNT_BITS'(1) && first_dn_reg)
        begin
            cur_next = rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_dn_reg <= 1'b0;
        end
        else
        begin
            first_dn_reg <= (state_reg == S_EX_RD_LAST);
        end
    end

    assign m_axis_tdata = {3'b000, status_reg, visit_reg, fill_reg, rem_reg};

    // assertions
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= COUNT_BITS'(CAPACITY))
        else $error("fill count above capacity");
    a_visit_mono: assert property (@(posedge clk) disable iff (!rst_n)
        visit_reg >= $past(visit_reg) || !$past(rst_n))
        else $error("visit counter decreased");
    a_refuse_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status_reg != ST_OK) |-> $stable(fill_reg))
        else $error("refused op changed fill count");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");
endmodule
`default_nettype wire
